// ===== src/x86enc_pkg.sv =====
// Package: widths, command codes, opcode constants and the shared entry types.
package x86enc_pkg;

  localparam int CMD_W     = 5;
  localparam int REG_W     = 4;
  localparam int VAL_W     = 64;
  localparam int MAX_BYTES = 10;
  localparam int LEN_W     = 4;
  localparam int IDX_W     = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_RBP   = 5'd0,
    CMD_POP_RBP    = 5'd1,
    CMD_MOV_RBP_SP = 5'd2,
    CMD_MOV_SP_RBP = 5'd3,
    CMD_RET        = 5'd4,
    CMD_MOVSD_LD   = 5'd5,
    CMD_MOVSD_ST   = 5'd6,
    CMD_MOVSD_RR   = 5'd7,
    CMD_ADDSD      = 5'd8,
    CMD_SUBSD      = 5'd9,
    CMD_MULSD      = 5'd10,
    CMD_DIVSD      = 5'd11,
    CMD_UCOMISD    = 5'd12,
    CMD_MOV_IMM64  = 5'd13,
    CMD_XOR        = 5'd14,
    CMD_TEST       = 5'd15,
    CMD_JMP        = 5'd16,
    CMD_JE         = 5'd17,
    CMD_JNE        = 5'd18,
    CMD_SETA       = 5'd19,
    CMD_SETAE      = 5'd20,
    CMD_SETB       = 5'd21,
    CMD_SETBE      = 5'd22,
    CMD_SETE       = 5'd23,
    CMD_SETNE      = 5'd24
  } cmd_t;

  localparam logic [7:0] PFX_F2      = 8'hF2;
  localparam logic [7:0] PFX_66      = 8'h66;
  localparam logic [7:0] REX_PLAIN   = 8'h40;
  localparam logic [7:0] REX_W       = 8'h48;
  localparam logic [7:0] REX_R       = 8'h44;
  localparam logic [7:0] REX_B       = 8'h41;
  localparam logic [7:0] ESC_0F      = 8'h0F;
  localparam logic [7:0] MOD_DISP8   = 8'h40;
  localparam logic [7:0] MOD_DISP32  = 8'h80;
  localparam logic [7:0] MOD_REG     = 8'hC0;
  localparam logic [7:0] OP_MOV_IMM  = 8'hB8;
  localparam logic [7:0] OP_JMP      = 8'hE9;
  localparam logic [7:0] SIB_NOINDEX = 8'h24;

  typedef logic [MAX_BYTES-1:0][7:0] byte_buf_t;

  typedef struct packed {
    byte_buf_t         bytes;
    logic [LEN_W-1:0]  len;
  } enc_entry_t;

  typedef struct packed {
    logic       valid;
    enc_entry_t entry;
  } enc_push_t;

  function automatic logic [7:0] sse_opcode(input logic [CMD_W-1:0] cmd);
    logic [7:0] op;
    unique case (cmd)
      CMD_MOVSD_RR: op = 8'h10;
      CMD_ADDSD:    op = 8'h58;
      CMD_SUBSD:    op = 8'h5C;
      CMD_MULSD:    op = 8'h59;
      CMD_DIVSD:    op = 8'h5E;
      default:      op = 8'h2E;
    endcase
    return op;
  endfunction

  function automatic logic [7:0] setcc_opcode(input logic [CMD_W-1:0] cmd);
    logic [7:0] op;
    unique case (cmd)
      CMD_SETA:  op = 8'h97;
      CMD_SETAE: op = 8'h93;
      CMD_SETB:  op = 8'h92;
      CMD_SETBE: op = 8'h96;
      CMD_SETE:  op = 8'h94;
      default:   op = 8'h95;
    endcase
    return op;
  endfunction

endpackage

// ===== src/x86enc_if.sv =====
// Interfaces: request channel and code byte channel.
interface x86enc_req_if import x86enc_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [REG_W-1:0]        reg_a;
  logic [REG_W-1:0]        reg_b;
  logic signed [VAL_W-1:0] value;

  modport source(output valid, command, reg_a, reg_b, value, input ready);
  modport sink(input valid, command, reg_a, reg_b, value, output ready);
endinterface

interface x86enc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source(output valid, code_byte, last_byte, input ready);
  modport sink(input valid, code_byte, last_byte, output ready);
endinterface

// ===== src/x86_sse_instruction_encoder_top.sv =====
// Top level: x86-64 SSE instruction encoder, request in, code bytes out.
// The request's bytes pass through a queue entry and then the output byte register.
// Output: one code byte per cycle while out_byte.ready is high; an instruction
// has 1 to 10 bytes, all sent through the single output byte register in the back end.
// A two-entry queue lets requests be taken while earlier bytes still drain.
// Reset (synchronous, rst_n low) empties the queue and the output register.
module x86_sse_instruction_encoder_top import x86enc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  x86enc_req_if.sink    in_req,
  x86enc_byte_if.source out_byte
);

  enc_push_t  push;
  logic       q_full, head_valid, pop;
  enc_entry_t head;

  x86enc_front u_front (
    .in_req (in_req),
    .q_full (q_full),
    .push   (push)
  );

  x86enc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  x86enc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_byte   (out_byte)
  );

endmodule

// ===== src/x86enc_front.sv =====
// Front end: accepts a request and packs its encoded bytes into one queue entry.
module x86enc_front import x86enc_pkg::*; (
  x86enc_req_if.sink  in_req,
  input  logic        q_full,
  output enc_push_t   push
);

  logic [2:0]  ra_lo, rb_lo;
  logic        ra_hi, rb_hi;
  logic [31:0] lo;
  logic        fits8, no_disp;
  logic [7:0]  rex_xmm, rex_alu, modrm_rm;
  byte_buf_t   b;
  logic [IDX_W-1:0] n;

  assign ra_lo = in_req.reg_a[2:0];
  assign rb_lo = in_req.reg_b[2:0];
  assign ra_hi = in_req.reg_a[3];
  assign rb_hi = in_req.reg_b[3];
  assign lo    = in_req.value[31:0];

  assign fits8   = (lo <= 32'h0000_007F) || (lo >= 32'hFFFF_FF80);
  // rbp/r13 base cannot use mod 00, so it falls back to disp8 of zero
  assign no_disp = (lo == 32'd0) && (rb_lo != 3'd5);
  assign rex_xmm = (ra_hi ? REX_R : 8'h00) | (rb_hi ? REX_B : 8'h00);
  // xor/test: destination in rm (REX.B), source in reg (REX.R)
  assign rex_alu = REX_W | {7'd0, ra_hi} | {5'd0, rb_hi, 2'd0};
  assign modrm_rm = {2'b00, ra_lo, rb_lo};

  assign in_req.ready = !q_full;

  always_comb begin
    b = '0;
    n = '0;
    case (in_req.command) inside
      CMD_PUSH_RBP: begin
        b[n] = 8'h55; n = n + 1'b1;
      end
      CMD_POP_RBP: begin
        b[n] = 8'h5D; n = n + 1'b1;
      end
      CMD_MOV_RBP_SP, CMD_MOV_SP_RBP: begin
        b[n] = REX_W; n = n + 1'b1;
        b[n] = 8'h89; n = n + 1'b1;
        b[n] = (in_req.command == CMD_MOV_RBP_SP) ? 8'hE5 : 8'hEC; n = n + 1'b1;
      end
      CMD_RET: begin
        b[n] = 8'hC3; n = n + 1'b1;
      end
      CMD_MOVSD_LD, CMD_MOVSD_ST: begin
        b[n] = PFX_F2; n = n + 1'b1;
        if (rex_xmm != 8'h00) begin
          b[n] = rex_xmm; n = n + 1'b1;
        end
        b[n] = ESC_0F; n = n + 1'b1;
        b[n] = (in_req.command == CMD_MOVSD_LD) ? 8'h10 : 8'h11; n = n + 1'b1;
        if (no_disp) b[n] = modrm_rm;
        else if (fits8) b[n] = MOD_DISP8 | modrm_rm;
        else b[n] = MOD_DISP32 | modrm_rm;
        n = n + 1'b1;
        if (rb_lo == 3'd4) begin
          b[n] = SIB_NOINDEX; n = n + 1'b1;
        end
        if (!no_disp) begin
          b[n] = lo[7:0]; n = n + 1'b1;
          if (!fits8) begin
            b[n] = lo[15:8];  n = n + 1'b1;
            b[n] = lo[23:16]; n = n + 1'b1;
            b[n] = lo[31:24]; n = n + 1'b1;
          end
        end
      end
      [CMD_MOVSD_RR:CMD_UCOMISD]: begin
        b[n] = (in_req.command == CMD_UCOMISD) ? PFX_66 : PFX_F2; n = n + 1'b1;
        if (rex_xmm != 8'h00) begin
          b[n] = rex_xmm; n = n + 1'b1;
        end
        b[n] = ESC_0F; n = n + 1'b1;
        b[n] = sse_opcode(in_req.command); n = n + 1'b1;
        b[n] = MOD_REG | modrm_rm; n = n + 1'b1;
      end
      CMD_MOV_IMM64: begin
        b[0] = REX_W | {7'd0, ra_hi};
        b[1] = OP_MOV_IMM + {5'd0, ra_lo};
        for (int i = 0; i < 8; i++) b[i+2] = in_req.value[8*i +: 8];
        n = IDX_W'(10);
      end
      CMD_XOR, CMD_TEST: begin
        b[0] = rex_alu;
        b[1] = (in_req.command == CMD_XOR) ? 8'h31 : 8'h85;
        b[2] = MOD_REG | {2'b00, rb_lo, ra_lo};
        n = IDX_W'(3);
      end
      CMD_JMP, CMD_JE, CMD_JNE: begin
        if (in_req.command == CMD_JMP) begin
          b[n] = OP_JMP; n = n + 1'b1;
        end else begin
          b[n] = ESC_0F; n = n + 1'b1;
          b[n] = (in_req.command == CMD_JE) ? 8'h84 : 8'h85; n = n + 1'b1;
        end
        b[n] = lo[7:0];   n = n + 1'b1;
        b[n] = lo[15:8];  n = n + 1'b1;
        b[n] = lo[23:16]; n = n + 1'b1;
        b[n] = lo[31:24]; n = n + 1'b1;
      end
      [CMD_SETA:CMD_SETNE]: begin
        // spl..dil need a bare REX, r8b..r15b need REX.B
        if (ra_hi) begin
          b[n] = REX_B; n = n + 1'b1;
        end else if (ra_lo[2]) begin
          b[n] = REX_PLAIN; n = n + 1'b1;
        end
        b[n] = ESC_0F; n = n + 1'b1;
        b[n] = setcc_opcode(in_req.command); n = n + 1'b1;
        b[n] = MOD_REG | {5'd0, ra_lo}; n = n + 1'b1;
      end
      default: begin
        n = '0;
      end
    endcase
  end

  // unused command codes produce no bytes and are dropped here
  assign push.valid       = in_req.valid && !q_full && (n != '0);
  assign push.entry.bytes = b;
  assign push.entry.len   = LEN_W'(n);

endmodule

// ===== src/x86enc_queue.sv =====
// Two-entry queue of encoded instructions between front and back end.
module x86enc_queue import x86enc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  enc_push_t  push,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output enc_entry_t head
);

  enc_entry_t entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = entries_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

// ===== src/x86enc_back.sv =====
// Back end: serializes the head entry into one registered code byte per transfer.
module x86enc_back import x86enc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  enc_entry_t          head,
  output logic                pop,
  x86enc_byte_if.source       out_byte
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       code_byte_r;
  logic             last_byte_r;
  logic             load, is_last;

  assign load    = head_valid && (!out_valid_r || out_byte.ready);
  assign is_last = (idx_r == IDX_W'(head.len - 1'b1));
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_byte.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_byte_r <= head.bytes[idx_r];
      last_byte_r <= is_last;
    end
  end

  assign out_byte.valid     = out_valid_r;
  assign out_byte.code_byte = code_byte_r;
  assign out_byte.last_byte = last_byte_r;

endmodule
